>>> hdl/rde_pkg.sv
// Package with the constants, operation codes and shared types of the reversible deque engine.
`default_nettype none
package rde_pkg;

	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 16;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int OP_W       = 3;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 3'd0,
		OP_APPEND  = 3'd1,
		OP_REVERSE = 3'd2,
		OP_DELETE  = 3'd3,
		OP_TAKE    = 3'd4
	} op_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] wrap_index(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(DEPTH)) begin
			s = s - (CNT_W+1)'(DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> hdl/rde_store.sv
// Element memory of the deque with one write port and one registered read port.
`default_nettype none
module rde_store (
	input  wire                            clk,
	input  rde_pkg::mem_req_t              req,
	output logic [rde_pkg::DATA_WIDTH-1:0] rd_data
);
	import rde_pkg::*;

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/rde_ctrl.sv
// Pointer, count and flag control of the deque, with the result stage.
`default_nettype none
module rde_ctrl (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            accept,
	input  wire  [rde_pkg::OP_W-1:0]       op,
	input  wire  [rde_pkg::DATA_WIDTH-1:0] value,
	output rde_pkg::mem_req_t              req,
	input  wire  [rde_pkg::DATA_WIDTH-1:0] rd_data,
	output logic                           done,
	output logic [rde_pkg::DATA_WIDTH-1:0] data,
	output logic                           data_valid,
	output logic                           last,
	output logic                           error,
	output logic [rde_pkg::CNT_W-1:0]      count
);
	import rde_pkg::*;

	logic [ADDR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              rev_q, rev_d;
	logic              err_q, err_d;
	logic              took;
	logic              valid_s1;
	logic              take_s1;

	always_comb begin
		head_d = head_q;
		cnt_d  = cnt_q;
		rev_d  = rev_q;
		err_d  = err_q;
		took   = 1'b0;
		req    = '0;
		if (accept) begin
			unique case (op_t'(op))
				OP_CLEAR: begin
					head_d = '0;
					cnt_d  = '0;
					rev_d  = 1'b0;
					err_d  = 1'b0;
				end
				OP_APPEND: begin
					if (cnt_q >= CNT_W'(DEPTH)) begin
						err_d = 1'b1;
					end else begin
						req.we    = 1'b1;
						req.waddr = wrap_index(head_q, cnt_q);
						req.wdata = value;
						cnt_d     = cnt_q + CNT_W'(1);
					end
				end
				OP_REVERSE: begin
					rev_d = ~rev_q;
				end
				OP_DELETE: begin
					if (!err_q) begin
						if (cnt_q == '0) begin
							err_d = 1'b1;
						end else begin
							if (!rev_q) begin
								head_d = wrap_index(head_q, CNT_W'(1));
							end
							cnt_d = cnt_q - CNT_W'(1);
						end
					end
				end
				OP_TAKE: begin
					if (cnt_q != '0) begin
						took      = 1'b1;
						req.re    = 1'b1;
						req.raddr = rev_q ? wrap_index(head_q, cnt_q - CNT_W'(1)) : head_q;
						if (!rev_q) begin
							head_d = wrap_index(head_q, CNT_W'(1));
						end
						cnt_d = cnt_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			cnt_q    <= '0;
			rev_q    <= 1'b0;
			err_q    <= 1'b0;
			valid_s1 <= 1'b0;
			take_s1  <= 1'b0;
		end else begin
			head_q   <= head_d;
			cnt_q    <= cnt_d;
			rev_q    <= rev_d;
			err_q    <= err_d;
			valid_s1 <= accept;
			take_s1  <= took;
		end
	end

	assign done       = valid_s1;
	assign data       = take_s1 ? rd_data : '0;
	assign data_valid = take_s1;
	assign last       = (cnt_q == '0);
	assign error      = err_q;
	assign count      = cnt_q;

endmodule
`default_nettype wire

>>> hdl/reversible_deque_engine_unit.sv
// Top level of the reversible deque engine: control and element memory.
//
//   Channel   Signals                                     Transaction at
//   command   start, busy, op, value                      start && !busy
//   result    done, data, data_valid, last, error, count  done
//
// One transaction is accepted in every cycle; busy stays low.
// Each result appears in the cycle after its command, when the memory read of a take returns.
// The element memory has one write and one read port and needs no clearing after reset.
// Reset clears the pointer, count, orientation and error flag.
// The receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none
module reversible_deque_engine_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           busy,
	input  wire  [rde_pkg::OP_W-1:0]       op,
	input  wire  [rde_pkg::DATA_WIDTH-1:0] value,
	output logic                           done,
	output logic [rde_pkg::DATA_WIDTH-1:0] data,
	output logic                           data_valid,
	output logic                           last,
	output logic                           error,
	output logic [rde_pkg::CNT_W-1:0]      count
);
	import rde_pkg::*;

	mem_req_t              req;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	rde_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.value      (value),
		.req        (req),
		.rd_data    (rd_data),
		.done       (done),
		.data       (data),
		.data_valid (data_valid),
		.last       (last),
		.error      (error),
		.count      (count)
	);

	rde_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

endmodule
`default_nettype wire

>>> hdl/rde_checker.sv
// Port-level checker of the reversible deque engine, bound to the top level.
`default_nettype none
module rde_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            start,
	input wire                            busy,
	input wire                            done,
	input wire [rde_pkg::DATA_WIDTH-1:0]  data,
	input wire                            data_valid,
	input wire                            last,
	input wire [rde_pkg::CNT_W-1:0]       count
);
	import rde_pkg::*;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("A transaction produced no result.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("A result appeared without a transaction.");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !data_valid) |-> (data == '0))
		else $error("Data is nonzero on a result without an element.");

	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((last == (count == '0)) && (count <= CNT_W'(DEPTH))))
		else $error("Last flag or count is inconsistent.");

endmodule

bind reversible_deque_engine_unit rde_checker u_rde_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.data       (data),
	.data_valid (data_valid),
	.last       (last),
	.count      (count)
);
`default_nettype wire
